/* design/mwd_pkg.sv */
package mwd_pkg;

  localparam int unsigned DigitWidth = 32;
  localparam int unsigned MaxDigits  = 16;
  localparam int unsigned DigitIdxW  = $clog2(MaxDigits);
  localparam int unsigned LenW       = $clog2(MaxDigits + 1);
  localparam int unsigned BitPosW    = $clog2(DigitWidth);
  localparam int unsigned BitCntW    = $clog2(MaxDigits * DigitWidth);
  localparam int unsigned QuotDigits = MaxDigits + 1;
  localparam int unsigned QuotIdxW   = $clog2(QuotDigits);

  typedef logic [DigitWidth-1:0] digit_t;

  typedef enum logic [1:0] {
    OP_LOAD_DIVIDEND = 2'd0,
    OP_LOAD_DIVISOR  = 2'd1,
    OP_START         = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_QUOTIENT  = 2'd0,
    KIND_REMAINDER = 2'd1,
    KIND_ERROR     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR,
    ST_DIV,
    ST_EMIT_Q,
    ST_EMIT_R,
    ST_ERROR
  } state_e;

endpackage

/* design/mwd_if.sv */
interface mwd_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic [3:0]                          digit_index;
  logic [31:0]                         digit_value;
  logic [4:0]                          dividend_len;
  logic [4:0]                          divisor_len;

  modport source (output valid, operation, digit_index, digit_value, dividend_len,
                  divisor_len, input ready);
  modport sink (input valid, operation, digit_index, digit_value, dividend_len,
                divisor_len, output ready);
endinterface

interface mwd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  out_index;
  logic [31:0] out_digit;
  logic        last;

  modport source (output valid, kind, out_index, out_digit, last, input ready);
  modport sink (input valid, kind, out_index, out_digit, last, output ready);
endinterface

/* design/multiword_integer_divider.sv */
// Unsigned multi-digit divider. Load requests write one 32-bit digit into the
// dividend or divisor store. A start request divides the first dividend_len
// dividend digits by the first divisor_len divisor digits and returns the quotient
// digits, then the remainder digits, low digit first, with last set on the final
// one; an invalid divisor (zero length, a length above 16 or a zero top digit) or a
// dividend length above 16 returns a single error result. The results follow at
// one result per cycle while the receiver keeps up, with the output idle between
// the quotient and the remainder digits: one 32-bit subtractor walks the divisor
// digits once for every dividend bit (restoring shift-subtract), so the cost is set
// by that digit loop. No new request is taken until the final result of a division
// has been loaded into the output register.
module multiword_integer_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  mwd_in_if.sink        in_i,
  mwd_out_if.source     out_o
);

  mwd_pkg::digit_t dividend_q [mwd_pkg::MaxDigits];
  mwd_pkg::digit_t divisor_q  [mwd_pkg::MaxDigits];
  mwd_pkg::digit_t quot_q     [mwd_pkg::QuotDigits];
  mwd_pkg::digit_t bank_q     [2][mwd_pkg::MaxDigits];

  mwd_pkg::state_e state_q, state_d;

  logic [mwd_pkg::LenW-1:0]      un_q, vn_q;
  logic [mwd_pkg::BitCntW-1:0]   bit_q;
  logic [mwd_pkg::DigitIdxW-1:0] dig_q;
  logic [mwd_pkg::LenW-1:0]      cnt_q;
  logic                          cur_q, msb_q, borrow_q;
  mwd_pkg::digit_t               qsh_q;

  logic                          out_valid_q;
  mwd_pkg::kind_e                kind_q;
  logic [mwd_pkg::LenW-1:0]      index_q;
  mwd_pkg::digit_t               digit_q;
  logic                          last_q;

  logic                          accept;
  logic                          slot_free;
  logic                          bad_div;
  logic [mwd_pkg::DigitIdxW-1:0] vtop;
  logic [mwd_pkg::LenW-1:0]      qlen;
  logic [mwd_pkg::DigitIdxW-1:0] vlast;
  logic                          pass_end;
  logic                          div_bit, cin;
  mwd_pkg::digit_t               cur_dig, shifted;
  logic [mwd_pkg::DigitWidth:0]  diff;
  logic                          ge;
  logic [mwd_pkg::LenW+mwd_pkg::BitPosW-1:0] bits_total;

  assign accept    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == mwd_pkg::ST_IDLE);

  assign vtop    = mwd_pkg::DigitIdxW'(vn_q - 1'b1);
  assign bad_div = (vn_q == '0) || (vn_q > mwd_pkg::LenW'(mwd_pkg::MaxDigits)) ||
                   (un_q > mwd_pkg::LenW'(mwd_pkg::MaxDigits)) || (divisor_q[vtop] == '0);
  assign qlen    = (un_q >= vn_q) ? mwd_pkg::LenW'(un_q - vn_q + 1'b1) : '0;
  assign vlast   = vtop;
  assign pass_end = (dig_q == vlast);
  assign bits_total = {un_q, {mwd_pkg::BitPosW{1'b0}}} - 1'b1;

  assign div_bit = dividend_q[bit_q[mwd_pkg::BitCntW-1:mwd_pkg::BitPosW]]
                             [bit_q[mwd_pkg::BitPosW-1:0]];
  assign cur_dig = bank_q[cur_q][dig_q];
  assign cin     = (dig_q == '0) ? div_bit : msb_q;
  assign shifted = {cur_dig[mwd_pkg::DigitWidth-2:0], cin};
  assign diff    = {1'b0, shifted} - {1'b0, divisor_q[dig_q]} -
                   {{mwd_pkg::DigitWidth{1'b0}}, borrow_q};
  // a shifted-out top bit means the partial remainder already exceeds the divisor
  assign ge      = cur_dig[mwd_pkg::DigitWidth-1] || !diff[mwd_pkg::DigitWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mwd_pkg::ST_IDLE: begin
        if (accept && (mwd_pkg::op_e'(in_i.operation) == mwd_pkg::OP_START)) begin
          state_d = mwd_pkg::ST_CHECK;
        end
      end
      mwd_pkg::ST_CHECK: begin
        state_d = bad_div ? mwd_pkg::ST_ERROR : mwd_pkg::ST_CLEAR;
      end
      mwd_pkg::ST_CLEAR: begin
        if (dig_q == mwd_pkg::DigitIdxW'(mwd_pkg::MaxDigits - 1)) begin
          state_d = (un_q == '0) ? mwd_pkg::ST_EMIT_Q : mwd_pkg::ST_DIV;
        end
      end
      mwd_pkg::ST_DIV: begin
        if (pass_end && (bit_q == '0)) begin
          state_d = mwd_pkg::ST_EMIT_Q;
        end
      end
      mwd_pkg::ST_EMIT_Q: begin
        if (cnt_q >= qlen) begin
          state_d = mwd_pkg::ST_EMIT_R;
        end
      end
      mwd_pkg::ST_EMIT_R: begin
        if (slot_free && (cnt_q == mwd_pkg::LenW'(vlast))) begin
          state_d = mwd_pkg::ST_IDLE;
        end
      end
      mwd_pkg::ST_ERROR: begin
        if (slot_free) begin
          state_d = mwd_pkg::ST_IDLE;
        end
      end
      default: state_d = mwd_pkg::ST_IDLE;
    endcase
  end

  // stores and working digits
  always_ff @(posedge clk_i) begin
    if (accept) begin
      case (mwd_pkg::op_e'(in_i.operation))
        mwd_pkg::OP_LOAD_DIVIDEND: dividend_q[in_i.digit_index] <= in_i.digit_value;
        mwd_pkg::OP_LOAD_DIVISOR:  divisor_q[in_i.digit_index]  <= in_i.digit_value;
        mwd_pkg::OP_START: begin
          un_q <= in_i.dividend_len;
          vn_q <= in_i.divisor_len;
        end
        default: ;
      endcase
    end
    if (state_q == mwd_pkg::ST_CLEAR) begin
      bank_q[cur_q][dig_q] <= '0;
    end
    if (state_q == mwd_pkg::ST_DIV) begin
      bank_q[cur_q][dig_q]  <= shifted;
      bank_q[!cur_q][dig_q] <= diff[mwd_pkg::DigitWidth-1:0];
      if (pass_end) begin
        qsh_q <= {qsh_q[mwd_pkg::DigitWidth-2:0], ge};
        if (bit_q[mwd_pkg::BitPosW-1:0] == '0) begin
          quot_q[mwd_pkg::QuotIdxW'(bit_q[mwd_pkg::BitCntW-1:mwd_pkg::BitPosW])] <=
            {qsh_q[mwd_pkg::DigitWidth-2:0], ge};
        end
      end
    end
  end

  // sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q    <= '0;
      dig_q    <= '0;
      cnt_q    <= '0;
      cur_q    <= 1'b0;
      msb_q    <= 1'b0;
      borrow_q <= 1'b0;
    end else begin
      case (state_q)
        mwd_pkg::ST_CHECK: begin
          dig_q <= '0;
          cnt_q <= '0;
        end
        mwd_pkg::ST_CLEAR: begin
          dig_q    <= dig_q + 1'b1;
          bit_q    <= bits_total[mwd_pkg::BitCntW-1:0];
          msb_q    <= 1'b0;
          borrow_q <= 1'b0;
        end
        mwd_pkg::ST_DIV: begin
          if (pass_end) begin
            dig_q    <= '0;
            borrow_q <= 1'b0;
            msb_q    <= 1'b0;
            bit_q    <= bit_q - 1'b1;
            // keep the difference when the divisor fitted
            if (ge) begin
              cur_q <= !cur_q;
            end
          end else begin
            dig_q    <= dig_q + 1'b1;
            msb_q    <= cur_dig[mwd_pkg::DigitWidth-1];
            borrow_q <= diff[mwd_pkg::DigitWidth];
          end
        end
        mwd_pkg::ST_EMIT_Q: begin
          if (cnt_q >= qlen) begin
            cnt_q <= '0;
          end else if (slot_free) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        mwd_pkg::ST_EMIT_R: begin
          if (slot_free) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= ((state_q == mwd_pkg::ST_EMIT_Q) && (cnt_q < qlen)) ||
                     (state_q == mwd_pkg::ST_EMIT_R) || (state_q == mwd_pkg::ST_ERROR);
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      case (state_q)
        mwd_pkg::ST_EMIT_Q: begin
          kind_q  <= mwd_pkg::KIND_QUOTIENT;
          index_q <= cnt_q;
          digit_q <= quot_q[mwd_pkg::QuotIdxW'(cnt_q)];
          last_q  <= 1'b0;
        end
        mwd_pkg::ST_EMIT_R: begin
          kind_q  <= mwd_pkg::KIND_REMAINDER;
          index_q <= cnt_q;
          digit_q <= bank_q[cur_q][cnt_q[mwd_pkg::DigitIdxW-1:0]];
          last_q  <= (cnt_q == mwd_pkg::LenW'(vlast));
        end
        mwd_pkg::ST_ERROR: begin
          kind_q  <= mwd_pkg::KIND_ERROR;
          index_q <= '0;
          digit_q <= '0;
          last_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = kind_q;
  assign out_o.out_index = index_q;
  assign out_o.out_digit = digit_q;
  assign out_o.last      = last_q;

`ifndef NO_ASSERTIONS
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == mwd_pkg::KIND_ERROR)) |-> (last_q && (digit_q == '0)))
    else $error("error result without last");

  a_div_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mwd_pkg::ST_DIV) |-> (mwd_pkg::LenW'(dig_q) < vn_q))
    else $error("digit walk beyond divisor length");

  a_rem_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == mwd_pkg::KIND_REMAINDER)) |->
      (index_q < mwd_pkg::LenW'(mwd_pkg::MaxDigits)))
    else $error("remainder index beyond the store");
`endif

endmodule
